// ===== rtl/ccs_pkg.sv =====
`timescale 1ns / 1ps
// Coin classifier/sorter package: destination codes, register indexes,
// window tables and the item types passed between front, queue and back.
package ccs_pkg;

	localparam int NUM_DENOM = 5;
	localparam int W_WIDTH   = 12;
	localparam int FILL_W    = 18;

	typedef enum logic [2:0] {
		DEST_IGNORED = 3'd0,
		DEST_NICKEL  = 3'd1,
		DEST_DIME    = 3'd2,
		DEST_QUARTER = 3'd3,
		DEST_LOONIE  = 3'd4,
		DEST_TOONIE  = 3'd5,
		DEST_BENT    = 3'd6,
		DEST_OTHER   = 3'd7
	} dest_t;

	typedef enum logic [2:0] {
		CFG_NICKEL_ROLL  = 3'd0,
		CFG_DIME_ROLL    = 3'd1,
		CFG_QUARTER_ROLL = 3'd2,
		CFG_LOONIE_ROLL  = 3'd3,
		CFG_TOONIE_ROLL  = 3'd4,
		CFG_BENT_LIMIT   = 3'd5,
		CFG_OTHER_LIMIT  = 3'd6,
		CFG_UNUSED       = 3'd7
	} cfg_idx_t;

	localparam logic [1:0] BENT_OK      = 2'd0;
	localparam logic [1:0] BENT_YES     = 2'd1;
	localparam logic [1:0] MATCH_BOTH   = 2'd0;
	localparam logic [1:0] MATCH_INVAL  = 2'd3;

	// Windows in 1/2550 mm and 1/25500 g, exclusive bounds
	localparam logic [16:0] DIA_LO [NUM_DENOM] = '{17'd51510, 17'd44115, 17'd58140,
		17'd63750, 17'd68595};
	localparam logic [16:0] DIA_HI [NUM_DENOM] = '{17'd55590, 17'd47685, 17'd62730,
		17'd68850, 17'd74205};
	localparam logic [17:0] WT_LO [NUM_DENOM] = '{18'd91800, 18'd33150, 18'd102000,
		18'd165750, 18'd172125};
	localparam logic [17:0] WT_HI [NUM_DENOM] = '{18'd109650, 18'd56100, 18'd122400,
		18'd191250, 18'd200175};

	localparam logic [5:0] ROLL_RESET [NUM_DENOM] = '{6'd40, 6'd50, 6'd40, 6'd25, 6'd25};
	localparam logic [9:0] BENT_LIMIT_RESET  = 10'd100;
	localparam logic [9:0] OTHER_LIMIT_RESET = 10'd200;

	typedef struct packed {
		logic [NUM_DENOM-1:0][5:0] roll_size;
		logic [9:0]                bent_limit;
		logic [9:0]                other_limit;
	} cfg_t;

	typedef struct packed {
		dest_t              dest;
		logic [W_WIDTH-1:0] w;
	} item_t;

	typedef struct packed {
		dest_t             destination;
		logic              replaced;
		logic [FILL_W-1:0] fill_level;
		logic [15:0]       filled_count;
		logic [15:0]       other_coin_total;
		logic [15:0]       other_coins_in_bin;
		logic [31:0]       bent_weight_total;
		logic [31:0]       other_weight_total;
	} res_t;

endpackage

// ===== rtl/coin_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: one coin reading per transfer.
// No dependencies.
interface coin_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] weight_raw;
	logic [7:0] diameter_raw;
	logic [1:0] bent_code;
	logic [1:0] match_code;

	modport source (output valid, weight_raw, diameter_raw, bent_code, match_code,
		input ready);
	modport sink (input valid, weight_raw, diameter_raw, bent_code, match_code,
		output ready);
endinterface

// ===== rtl/coin_out_if.sv =====
`timescale 1ns / 1ps
// Output channel: one sorting result per transfer.
// No dependencies.
interface coin_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  destination;
	logic        replaced;
	logic [17:0] fill_level;
	logic [15:0] filled_count;
	logic [15:0] other_coin_total;
	logic [15:0] other_coins_in_bin;
	logic [31:0] bent_weight_total;
	logic [31:0] other_weight_total;

	modport source (output valid, destination, replaced, fill_level, filled_count,
		other_coin_total, other_coins_in_bin, bent_weight_total, other_weight_total,
		input ready);
	modport sink (input valid, destination, replaced, fill_level, filled_count,
		other_coin_total, other_coins_in_bin, bent_weight_total, other_weight_total,
		output ready);
endinterface

// ===== rtl/ccs_front.sv =====
`timescale 1ns / 1ps
// Front stage: accepts coin readings, classifies destination, registers the item.
// Depends on ccs_pkg and coin_in_if.
module ccs_front import ccs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	coin_in_if.sink     coin_in,
	output logic        item_valid,
	output item_t       item,
	input  logic        item_ready
);

	logic        v_s1;
	item_t       item_s1;
	item_t       cls;
	logic [16:0] d10;
	logic [17:0] w100;
	logic [NUM_DENOM-1:0] dia_hit;
	logic        found;
	logic        wt_ok;
	logic [2:0]  sel;

	assign coin_in.ready = !v_s1 || item_ready;
	assign d10  = 17'(coin_in.diameter_raw) * 17'd300 + 17'd25500;
	assign w100 = 18'(coin_in.weight_raw) * 18'd1000;

	always_comb begin
		for (int i = 0; i < NUM_DENOM; i++) begin
			dia_hit[i] = (d10 > DIA_LO[i]) && (d10 < DIA_HI[i]);
		end
		found = 1'b0;
		sel   = 3'd0;
		for (int i = NUM_DENOM - 1; i >= 0; i--) begin
			if (dia_hit[i]) begin
				found = 1'b1;
				sel   = 3'(i);
			end
		end
		wt_ok = (w100 > WT_LO[sel]) && (w100 < WT_HI[sel]);
		cls.w = W_WIDTH'(coin_in.weight_raw) * W_WIDTH'(10);
		if (coin_in.weight_raw == 8'd0 || coin_in.diameter_raw == 8'd0 ||
			(coin_in.bent_code != BENT_OK && coin_in.bent_code != BENT_YES) ||
			coin_in.match_code == MATCH_INVAL) begin
			cls.dest = DEST_IGNORED;
		end else if (coin_in.bent_code == BENT_YES) begin
			cls.dest = DEST_BENT;
		end else if (found && wt_ok && coin_in.match_code == MATCH_BOTH) begin
			cls.dest = dest_t'(sel + 3'd1);
		end else begin
			cls.dest = DEST_OTHER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (coin_in.ready) begin
			v_s1 <= coin_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (coin_in.ready && coin_in.valid) begin
			item_s1 <= cls;
		end
	end

	assign item_valid = v_s1;
	assign item       = item_s1;

endmodule

// ===== rtl/ccs_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue between front and back stages.
// Depends on ccs_pkg.
module ccs_queue import ccs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	input  item_t push_item,
	output logic  push_ready,
	output logic  pop_valid,
	output item_t pop_item,
	input  logic  pop_ready
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

endmodule

// ===== rtl/ccs_back.sv =====
`timescale 1ns / 1ps
// Back stage: updates wrappers, containers and totals; holds the result register.
// Depends on ccs_pkg and coin_out_if.
module ccs_back import ccs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       item_valid,
	input  item_t      item,
	output logic       item_ready,
	coin_out_if.source sort_out
);

	logic [5:0]        wrap_cnt_q [NUM_DENOM];
	logic [15:0]       roll_cnt_q [NUM_DENOM];
	logic [FILL_W-1:0] bent_bin_q, other_bin_q;
	logic [15:0]       bent_done_q, other_done_q, other_in_bin_q, other_total_q;
	logic [31:0]       bent_sum_q, other_sum_q;
	logic              out_valid_q;
	res_t              res_q;

	logic [5:0]        wrap_nxt;
	logic [15:0]       roll_nxt;
	logic [FILL_W-1:0] bent_bin_nxt, other_bin_nxt;
	logic [15:0]       bent_done_nxt, other_done_nxt, other_in_bin_nxt, other_total_nxt;
	logic [31:0]       bent_sum_nxt, other_sum_nxt;
	res_t              res;
	logic [2:0]        den;
	logic [FILL_W:0]   bin_sum;
	logic [FILL_W:0]   lim;
	logic [32:0]       sum33;
	logic              pop;

	assign item_ready = !out_valid_q || sort_out.ready;
	assign pop        = item_valid && item_ready;
	assign den        = 3'(item.dest) - 3'd1;

	always_comb begin
		wrap_nxt         = wrap_cnt_q[den];
		roll_nxt         = roll_cnt_q[den];
		bent_bin_nxt     = bent_bin_q;
		other_bin_nxt    = other_bin_q;
		bent_done_nxt    = bent_done_q;
		other_done_nxt   = other_done_q;
		other_in_bin_nxt = other_in_bin_q;
		other_total_nxt  = other_total_q;
		bent_sum_nxt     = bent_sum_q;
		other_sum_nxt    = other_sum_q;
		bin_sum          = '0;
		lim              = '0;
		sum33            = '0;
		res              = '0;
		res.destination  = item.dest;
		case (item.dest)
			DEST_BENT: begin
				sum33        = {1'b0, bent_sum_q} + 33'(item.w);
				bent_sum_nxt = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
				bin_sum      = {1'b0, bent_bin_q} + (FILL_W+1)'(item.w);
				lim          = (FILL_W+1)'({cfg.bent_limit, 8'd0}) -
					(FILL_W+1)'(cfg.bent_limit);
				if (bin_sum < lim) begin
					bent_bin_nxt = bin_sum[FILL_W-1:0];
				end else begin
					bent_bin_nxt  = FILL_W'(item.w);
					bent_done_nxt = (bent_done_q == 16'hFFFF) ? bent_done_q : bent_done_q + 16'd1;
					res.replaced  = 1'b1;
				end
				res.fill_level   = bent_bin_nxt;
				res.filled_count = bent_done_nxt;
			end
			DEST_OTHER: begin
				sum33         = {1'b0, other_sum_q} + 33'(item.w);
				other_sum_nxt = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
				bin_sum       = {1'b0, other_bin_q} + (FILL_W+1)'(item.w);
				lim           = (FILL_W+1)'({cfg.other_limit, 8'd0}) -
					(FILL_W+1)'(cfg.other_limit);
				if (bin_sum < lim) begin
					other_bin_nxt    = bin_sum[FILL_W-1:0];
					other_in_bin_nxt = (other_in_bin_q == 16'hFFFF) ? other_in_bin_q :
						other_in_bin_q + 16'd1;
				end else begin
					other_bin_nxt    = FILL_W'(item.w);
					other_done_nxt   = (other_done_q == 16'hFFFF) ? other_done_q :
						other_done_q + 16'd1;
					other_in_bin_nxt = 16'd1;
					res.replaced     = 1'b1;
				end
				other_total_nxt  = (other_total_q == 16'hFFFF) ? other_total_q :
					other_total_q + 16'd1;
				res.fill_level   = other_bin_nxt;
				res.filled_count = other_done_nxt;
			end
			DEST_NICKEL, DEST_DIME, DEST_QUARTER, DEST_LOONIE, DEST_TOONIE: begin
				if ({1'b0, wrap_cnt_q[den]} + 7'd1 < {1'b0, cfg.roll_size[den]}) begin
					wrap_nxt = wrap_cnt_q[den] + 6'd1;
				end else begin
					wrap_nxt     = 6'd1;
					roll_nxt     = (roll_cnt_q[den] == 16'hFFFF) ? roll_cnt_q[den] :
						roll_cnt_q[den] + 16'd1;
					res.replaced = 1'b1;
				end
				res.fill_level   = FILL_W'(wrap_nxt);
				res.filled_count = roll_nxt;
			end
			default: begin
				res.destination = DEST_IGNORED;
			end
		endcase
		res.other_coin_total   = other_total_nxt;
		res.other_coins_in_bin = other_in_bin_nxt;
		res.bent_weight_total  = bent_sum_nxt;
		res.other_weight_total = other_sum_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DENOM; i++) begin
				wrap_cnt_q[i] <= '0;
				roll_cnt_q[i] <= '0;
			end
			bent_bin_q     <= '0;
			other_bin_q    <= '0;
			bent_done_q    <= '0;
			other_done_q   <= '0;
			other_in_bin_q <= '0;
			other_total_q  <= '0;
			bent_sum_q     <= '0;
			other_sum_q    <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (item_ready) out_valid_q <= item_valid;
			if (pop) begin
				if (item.dest inside {DEST_NICKEL, DEST_DIME, DEST_QUARTER, DEST_LOONIE,
					DEST_TOONIE}) begin
					wrap_cnt_q[den] <= wrap_nxt;
					roll_cnt_q[den] <= roll_nxt;
				end
				bent_bin_q     <= bent_bin_nxt;
				other_bin_q    <= other_bin_nxt;
				bent_done_q    <= bent_done_nxt;
				other_done_q   <= other_done_nxt;
				other_in_bin_q <= other_in_bin_nxt;
				other_total_q  <= other_total_nxt;
				bent_sum_q     <= bent_sum_nxt;
				other_sum_q    <= other_sum_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) res_q <= res;
	end

	assign sort_out.valid              = out_valid_q;
	assign sort_out.destination        = 3'(res_q.destination);
	assign sort_out.replaced           = res_q.replaced;
	assign sort_out.fill_level         = res_q.fill_level;
	assign sort_out.filled_count       = res_q.filled_count;
	assign sort_out.other_coin_total   = res_q.other_coin_total;
	assign sort_out.other_coins_in_bin = res_q.other_coins_in_bin;
	assign sort_out.bent_weight_total  = res_q.bent_weight_total;
	assign sort_out.other_weight_total = res_q.other_weight_total;

endmodule

// ===== rtl/coin_classifier_sorter.sv =====
`timescale 1ns / 1ps
// Coin classifier/sorter top: config registers, front classifier, queue, back stage.
// A coin passes the front register, a queue entry and the result register on its way out.
// Throughput: one coin per cycle unless sort_out stalls, set by the back stage update.
// Asynchronous active-low reset clears all counters, containers and totals and loads
// default roll sizes/limits.
module coin_classifier_sorter import ccs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [9:0] cfg_data,
	coin_in_if.sink    coin_in,
	coin_out_if.source sort_out
);

	cfg_t  cfg_q;
	logic  f_valid, f_ready;
	item_t f_item;
	logic  b_valid, b_ready;
	item_t b_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DENOM; i++) begin
				cfg_q.roll_size[i] <= ROLL_RESET[i];
			end
			cfg_q.bent_limit  <= BENT_LIMIT_RESET;
			cfg_q.other_limit <= OTHER_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index)) inside
				[CFG_NICKEL_ROLL:CFG_TOONIE_ROLL]: cfg_q.roll_size[cfg_index] <= cfg_data[5:0];
				CFG_BENT_LIMIT:  cfg_q.bent_limit  <= cfg_data;
				CFG_OTHER_LIMIT: cfg_q.other_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	ccs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.coin_in    (coin_in),
		.item_valid (f_valid),
		.item       (f_item),
		.item_ready (f_ready)
	);

	ccs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_item  (f_item),
		.push_ready (f_ready),
		.pop_valid  (b_valid),
		.pop_item   (b_item),
		.pop_ready  (b_ready)
	);

	ccs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (b_valid),
		.item       (b_item),
		.item_ready (b_ready),
		.sort_out   (sort_out)
	);

endmodule

// ===== sim/coin_classifier_sorter_tb.sv =====
`timescale 1ns / 1ps
// Testbench for coin_classifier_sorter: directed and random coin readings under several
// register settings, with random source gaps and sink stalls, checked by an in-bench model.
// Depends on ccs_pkg, coin_in_if, coin_out_if and the coin_classifier_sorter RTL.
module coin_classifier_sorter_tb;
	import ccs_pkg::*;

	typedef struct packed {
		logic [7:0] weight_raw;
		logic [7:0] diameter_raw;
		logic [1:0] bent_code;
		logic [1:0] match_code;
	} coin_t;

	typedef logic [9:0] reg_vals_t [8];

	// diameter in 1/2550 mm, weight in 1/25500 g
	localparam int DIA_CTR [NUM_DENOM] = '{53550, 45900, 60435, 66300, 71400};
	localparam int DIA_TOL [NUM_DENOM] = '{2040, 1785, 2295, 2550, 2805};
	localparam int WT_CTR [NUM_DENOM] = '{100725, 44625, 112200, 178500, 186150};
	localparam int WT_TOL [NUM_DENOM] = '{8925, 11475, 10200, 12750, 14025};
	localparam dest_t DENOM_DEST [NUM_DENOM] = '{DEST_NICKEL, DEST_DIME, DEST_QUARTER,
		DEST_LOONIE, DEST_TOONIE};
	localparam cfg_idx_t REG_ORDER [8] = '{CFG_NICKEL_ROLL, CFG_DIME_ROLL, CFG_QUARTER_ROLL,
		CFG_LOONIE_ROLL, CFG_TOONIE_ROLL, CFG_BENT_LIMIT, CFG_OTHER_LIMIT, CFG_UNUSED};
	localparam logic [1:0] BENT_BAD = 2'd2;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic [9:0] cfg_data;

	coin_in_if  coin_in ();
	coin_out_if sort_out ();

	coin_classifier_sorter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.coin_in  (coin_in),
		.sort_out (sort_out)
	);

	// sorter model: registers and state
	logic [5:0]  roll_size [NUM_DENOM];
	logic [9:0]  bent_limit;
	logic [9:0]  other_limit;
	logic [5:0]  wrap_cnt [NUM_DENOM];
	logic [15:0] rolls_done [NUM_DENOM];
	logic [17:0] bent_bin;
	logic [17:0] other_bin;
	logic [15:0] bent_done;
	logic [15:0] other_done;
	logic [15:0] other_in_bin;
	logic [15:0] other_coins;
	logic [31:0] bent_sum;
	logic [31:0] other_sum;

	res_t pending_sorts [$];
	int   errors;
	bit   idle_on;
	int   stall_left;
	int   dia_lo_raw [NUM_DENOM];
	int   dia_hi_raw [NUM_DENOM];
	int   wt_lo_raw [NUM_DENOM];
	int   wt_hi_raw [NUM_DENOM];

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit in_window(input int x, input int ctr, input int tol);
		int diff;
		diff = x - ctr;
		if (diff < 0) diff = -diff;
		return diff < tol;
	endfunction

	function automatic logic [15:0] inc_sat16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic [31:0] add_sat32(input logic [31:0] a, input int b);
		logic [32:0] s;
		s = {1'b0, a} + 33'(b);
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic bit bin_add(inout logic [17:0] bin, inout logic [15:0] done,
		input logic [9:0] limit_g, input int w);
		if (int'(bin) + w < int'(limit_g) * 255) begin
			bin = 18'(int'(bin) + w);
			return 1'b0;
		end
		bin = 18'(w);
		done = inc_sat16(done);
		return 1'b1;
	endfunction

	function automatic void reset_model();
		for (int k = 0; k < NUM_DENOM; k++) begin
			roll_size[k] = ROLL_RESET[k];
			wrap_cnt[k] = '0;
			rolls_done[k] = '0;
		end
		bent_limit = BENT_LIMIT_RESET;
		other_limit = OTHER_LIMIT_RESET;
		bent_bin = '0;
		other_bin = '0;
		bent_done = '0;
		other_done = '0;
		other_in_bin = '0;
		other_coins = '0;
		bent_sum = '0;
		other_sum = '0;
	endfunction

	function automatic res_t sort_coin(input coin_t c);
		res_t r;
		int   w;
		int   sel;
		bit   repl;
		r = '0;
		r.destination = DEST_IGNORED;
		if (c.weight_raw != 0 && c.diameter_raw != 0 && c.bent_code <= BENT_YES &&
			c.match_code != MATCH_INVAL) begin
			w = int'(c.weight_raw) * 10;
			if (c.bent_code == BENT_YES) begin
				bent_sum = add_sat32(bent_sum, w);
				r.replaced = bin_add(bent_bin, bent_done, bent_limit, w);
				r.destination = DEST_BENT;
				r.fill_level = bent_bin;
				r.filled_count = bent_done;
			end else begin
				sel = -1;
				for (int k = NUM_DENOM - 1; k >= 0; k--)
					if (in_window(int'(c.diameter_raw) * 300 + 25500, DIA_CTR[k], DIA_TOL[k]))
						sel = k;
				if (sel >= 0 && c.match_code == MATCH_BOTH &&
					in_window(int'(c.weight_raw) * 1000, WT_CTR[sel], WT_TOL[sel])) begin
					if (int'(wrap_cnt[sel]) < int'(roll_size[sel]) - 1) begin
						wrap_cnt[sel] = wrap_cnt[sel] + 6'd1;
					end else begin
						wrap_cnt[sel] = 6'd1;
						rolls_done[sel] = inc_sat16(rolls_done[sel]);
						r.replaced = 1'b1;
					end
					r.destination = DENOM_DEST[sel];
					r.fill_level = 18'(wrap_cnt[sel]);
					r.filled_count = rolls_done[sel];
				end else begin
					repl = bin_add(other_bin, other_done, other_limit, w);
					other_in_bin = repl ? 16'd1 : inc_sat16(other_in_bin);
					other_sum = add_sat32(other_sum, w);
					other_coins = inc_sat16(other_coins);
					r.replaced = repl;
					r.destination = DEST_OTHER;
					r.fill_level = other_bin;
					r.filled_count = other_done;
				end
			end
		end
		r.other_coin_total = other_coins;
		r.other_coins_in_bin = other_in_bin;
		r.bent_weight_total = bent_sum;
		r.other_weight_total = other_sum;
		return r;
	endfunction

	function automatic void find_raw_ranges();
		for (int k = 0; k < NUM_DENOM; k++) begin
			dia_lo_raw[k] = -1;
			wt_lo_raw[k] = -1;
			for (int raw = 1; raw < 256; raw++) begin
				if (in_window(raw * 300 + 25500, DIA_CTR[k], DIA_TOL[k])) begin
					if (dia_lo_raw[k] < 0) dia_lo_raw[k] = raw;
					dia_hi_raw[k] = raw;
				end
				if (in_window(raw * 1000, WT_CTR[k], WT_TOL[k])) begin
					if (wt_lo_raw[k] < 0) wt_lo_raw[k] = raw;
					wt_hi_raw[k] = raw;
				end
			end
		end
	endfunction

	function automatic coin_t make_coin(input int w, input int d, input logic [1:0] b,
		input logic [1:0] m);
		coin_t c;
		c.weight_raw = 8'((w < 0) ? 0 : (w > 255) ? 255 : w);
		c.diameter_raw = 8'((d < 0) ? 0 : (d > 255) ? 255 : d);
		c.bent_code = b;
		c.match_code = m;
		return c;
	endfunction

	function automatic coin_t random_coin();
		int pick;
		int k;
		int d;
		int w;
		logic [1:0] m;
		pick = $urandom_range(0, 99);
		k = $urandom_range(0, NUM_DENOM - 1);
		d = $urandom_range(dia_lo_raw[k], dia_hi_raw[k]);
		w = $urandom_range(wt_lo_raw[k], wt_hi_raw[k]);
		m = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3)) : MATCH_BOTH;
		if (pick < 60)
			return make_coin(w, d, BENT_OK, m);
		if (pick < 70) begin
			if ($urandom_range(0, 1) == 0)
				d = $urandom_range(0, 1) ? dia_lo_raw[k] - 1 : dia_hi_raw[k] + 1;
			else
				w = $urandom_range(0, 1) ? wt_lo_raw[k] - 1 : wt_hi_raw[k] + 1;
			return make_coin(w, d, BENT_OK, MATCH_BOTH);
		end
		if (pick < 82)
			return make_coin($urandom_range(1, 255), $urandom_range(1, 255), BENT_YES,
				2'($urandom_range(0, 3)));
		return coin_t'($urandom);
	endfunction

	task automatic send_coin(input coin_t c);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			coin_in.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		coin_in.valid <= 1'b1;
		coin_in.weight_raw <= c.weight_raw;
		coin_in.diameter_raw <= c.diameter_raw;
		coin_in.bent_code <= c.bent_code;
		coin_in.match_code <= c.match_code;
		do @(posedge clk); while (!coin_in.ready);
		pending_sorts.push_back(sort_coin(c));
	endtask

	task automatic run_coins(input int n);
		for (int i = 0; i < n; i++) send_coin(random_coin());
	endtask

	task automatic drain();
		coin_in.valid <= 1'b0;
		while (pending_sorts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(input reg_vals_t v);
		drain();
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_ORDER[i];
			cfg_data <= v[i];
			@(posedge clk);
			if (i < NUM_DENOM) roll_size[i] = v[i][5:0];
			else case (REG_ORDER[i])
				CFG_BENT_LIMIT:  bent_limit = v[i];
				CFG_OTHER_LIMIT: other_limit = v[i];
				default: ;
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	task automatic test_directed_coins();
		send_coin(make_coin(0, 100, BENT_OK, MATCH_BOTH));
		send_coin(make_coin(100, 0, BENT_OK, MATCH_BOTH));
		send_coin(make_coin(40, 93, BENT_BAD, MATCH_BOTH));
		send_coin(make_coin(40, 93, 2'd3, MATCH_BOTH));
		send_coin(make_coin(40, 93, BENT_OK, MATCH_INVAL));
		send_coin(make_coin(255, 255, BENT_OK, MATCH_BOTH));
		send_coin(make_coin(255, 255, BENT_YES, 2'd2));
		send_coin(make_coin(1, 1, BENT_OK, MATCH_BOTH));
		for (int k = 0; k < NUM_DENOM; k++)
			send_coin(make_coin((wt_lo_raw[k] + wt_hi_raw[k]) / 2,
				(dia_lo_raw[k] + dia_hi_raw[k]) / 2, BENT_OK, MATCH_BOTH));
		for (int k = 0; k < NUM_DENOM; k++) begin
			send_coin(make_coin(wt_lo_raw[k], dia_lo_raw[k], BENT_OK, MATCH_BOTH));
			send_coin(make_coin(wt_hi_raw[k], dia_hi_raw[k], BENT_OK, MATCH_BOTH));
		end
		// one image or none matching
		send_coin(make_coin(wt_lo_raw[0], dia_lo_raw[0], BENT_OK, 2'd1));
		send_coin(make_coin(wt_lo_raw[0], dia_lo_raw[0], BENT_OK, 2'd2));
		// loonie and toonie diameters overlap; the loonie window wins, so the toonie weight sends it to other
		send_coin(make_coin(wt_hi_raw[4], dia_lo_raw[4], BENT_OK, MATCH_BOTH));
		drain();
	endtask

	task automatic test_roll_size_extremes();
		reg_vals_t v;
		v = '{10'd0, 10'd1, 10'd2, 10'd63, 10'h3FF, 10'd0, 10'd1, 10'h155};
		program_regs(v);
		run_coins(200);
		drain();
	endtask

	task automatic test_large_limits();
		reg_vals_t v;
		v = '{10'd63, 10'd63, 10'd63, 10'd63, 10'd63, 10'h3FF, 10'h3FF, 10'h2AA};
		program_regs(v);
		run_coins(300);
		drain();
	endtask

	task automatic test_lowered_settings();
		reg_vals_t v;
		v = '{10'd2, 10'd3, 10'd1, 10'd2, 10'd2, 10'd1, 10'd2, 10'd0};
		program_regs(v);
		run_coins(150);
		drain();
	endtask

	task automatic test_random_settings();
		reg_vals_t v;
		for (int p = 0; p < 4; p++) begin
			for (int i = 0; i < 8; i++)
				v[i] = $urandom_range(0, 1) ? 10'($urandom_range(0, 8)) : 10'($urandom);
			if ($urandom_range(0, 1)) v[5] = 10'($urandom_range(1, 30));
			if ($urandom_range(0, 1)) v[6] = 10'($urandom_range(1, 30));
			program_regs(v);
			run_coins(230);
		end
		drain();
	endtask

	task automatic test_full_rate_stream();
		reg_vals_t v;
		v = '{10'd40, 10'd50, 10'd40, 10'd25, 10'd25, 10'd100, 10'd200, 10'h3FF};
		program_regs(v);
		idle_on = 1'b0;
		run_coins(300);
		drain();
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			sort_out.ready <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			sort_out.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 12);
			sort_out.ready <= 1'b0;
		end else begin
			sort_out.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && sort_out.valid && sort_out.ready) begin
			got.destination = dest_t'(sort_out.destination);
			got.replaced = sort_out.replaced;
			got.fill_level = sort_out.fill_level;
			got.filled_count = sort_out.filled_count;
			got.other_coin_total = sort_out.other_coin_total;
			got.other_coins_in_bin = sort_out.other_coins_in_bin;
			got.bent_weight_total = sort_out.bent_weight_total;
			got.other_weight_total = sort_out.other_weight_total;
			if (pending_sorts.size() == 0) begin
				if (errors < 10)
					$display("%0t: result transfer with nothing pending, dest %0d", $realtime,
						got.destination);
				errors++;
			end else begin
				want = pending_sorts.pop_front();
				if (got !== want) begin
					if (errors < 10)
						$display({"%0t: mismatch exp/act dest %0d/%0d repl %0d/%0d ",
							"fill %0d/%0d done %0d/%0d ocnt %0d/%0d obin %0d/%0d ",
							"bsum %0d/%0d osum %0d/%0d"}, $realtime,
							want.destination, got.destination, want.replaced, got.replaced,
							want.fill_level, got.fill_level, want.filled_count,
							got.filled_count, want.other_coin_total, got.other_coin_total,
							want.other_coins_in_bin, got.other_coins_in_bin,
							want.bent_weight_total, got.bent_weight_total,
							want.other_weight_total, got.other_weight_total);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_UNUSED;
		cfg_data = '0;
		coin_in.valid = 1'b0;
		coin_in.weight_raw = '0;
		coin_in.diameter_raw = '0;
		coin_in.bent_code = BENT_OK;
		coin_in.match_code = MATCH_BOTH;
		sort_out.ready = 1'b0;
		errors = 0;
		idle_on = 1'b1;
		reset_model();
		find_raw_ranges();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_coins();
		test_roll_size_extremes();
		test_large_limits();
		test_lowered_settings();
		test_random_settings();
		test_full_rate_stream();

		repeat (10) @(posedge clk);
		if (errors == 0 && pending_sorts.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ccs_pkg.sv
rtl/coin_in_if.sv
rtl/coin_out_if.sv
rtl/ccs_front.sv
rtl/ccs_queue.sv
rtl/ccs_back.sv
rtl/coin_classifier_sorter.sv
sim/coin_classifier_sorter_tb.sv
